// ===== src/block_branch_target_buffer_top_assert.svh =====
// Assertion macros for the block branch target buffer.
// Depends on nothing; modules that check their own logic include this header.
`ifndef BLOCK_BRANCH_TARGET_BUFFER_TOP_ASSERT_SVH
`define BLOCK_BRANCH_TARGET_BUFFER_TOP_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define BBTB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define BBTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/bbtb_pkg.sv =====
// Shared types, codes and the slot merge function of the block branch target buffer.
// Depends on nothing.
package bbtb_pkg;

  localparam int PC_W   = 50;
  localparam int INFO_W = 51;
  localparam int OFF_W  = 4;
  localparam int KIND_W = 3;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_UPDATE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // One branch slot as it is stored.
  typedef struct packed {
    logic [INFO_W-1:0] info;
    logic [OFF_W-1:0]  offset;
    logic              valid;
  } slot_t;

  typedef struct packed {
    slot_t             s0;
    slot_t             s1;
    logic [PC_W-1:0]   ft;
    logic [KIND_W-1:0] kind;
  } merge_t;

  // Insert a new first slot into a stored entry in offset order.
  function automatic merge_t merge_slots(input slot_t o0, input slot_t o1, input slot_t n0,
                                         input logic [PC_W-1:0] pc,
                                         input logic [PC_W-1:0] ft_old,
                                         input logic [KIND_W-1:0] kind_old,
                                         input logic [PC_W-1:0] blk);
    merge_t r;
    slot_t  ns;
    r.s0   = o0;
    r.s1   = o1;
    r.ft   = ft_old;
    r.kind = kind_old;
    ns = n0;
    ns.info[INFO_W-1] = 1'b1;
    if (o0.valid && n0.valid && n0.offset < o0.offset) begin
      r.s0 = n0;
      r.s1 = o0;
      r.s1.info[INFO_W-1] = 1'b1;
      r.kind = '0;
      r.ft = o1.valid ? pc + {{(PC_W-OFF_W-1){1'b0}}, o1.offset, 1'b0} : blk;
    end else if (!o0.valid && n0.valid && o1.valid && n0.offset < o1.offset) begin
      r.s0 = n0;
    end else if (n0.valid && o0.valid && n0.offset > o0.offset && o1.valid &&
                 n0.offset < o1.offset) begin
      r.s1 = ns;
      r.kind = '0;
      r.ft = pc + {{(PC_W-OFF_W-1){1'b0}}, o1.offset, 1'b0};
    end else if (n0.valid && o0.valid && n0.offset > o0.offset && !o1.valid) begin
      r.s1 = ns;
      r.kind = '0;
      r.ft = blk;
    end else if (n0.valid && o1.valid && o0.valid && n0.offset > o1.offset) begin
      r.ft = pc + {{(PC_W-OFF_W-1){1'b0}}, n0.offset, 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== src/block_branch_target_buffer_top.sv =====
// Top level of the block branch target buffer: set memory, control and result register.
// Depends on bbtb_pkg and block_branch_target_buffer_top_assert.svh.

// For each command beat the set row is read from the synchronous memory in the idle state
// when the beat is taken, and is modified and written back in the execute state, so busy
// is high for one cycle after start and a new beat is taken only once busy is low again.
// The result is registered together with the write-back, with done high for exactly one
// cycle; it cannot be held off. After reset the block clears its valid bits and age
// counters row by row, keeping busy high and taking no command until every row is cleared.
module block_branch_target_buffer_top #(
  parameter int WAYS         = 4,
  parameter int SETS         = 256,
  parameter int TAG_BITS     = 16,
  parameter int LRU_BITS     = 2,
  parameter int BLOCK_INSTRS = 16,
  parameter int INST_SHIFT   = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation,
  input  logic [bbtb_pkg::PC_W-1:0]     pc,
  input  logic                          tid,
  input  logic                          merge_hint,
  input  logic                          slot0_valid,
  input  logic [bbtb_pkg::OFF_W-1:0]    slot0_offset,
  input  logic [bbtb_pkg::INFO_W-1:0]   slot0_info,
  input  logic                          slot1_valid,
  input  logic [bbtb_pkg::OFF_W-1:0]    slot1_offset,
  input  logic [bbtb_pkg::INFO_W-1:0]   slot1_info,
  input  logic [bbtb_pkg::PC_W-1:0]     fall_through,
  input  logic [bbtb_pkg::KIND_W-1:0]   kind_flags,
  output logic                          done,
  output logic                          hit,
  output logic                          out_slot0_valid,
  output logic [bbtb_pkg::OFF_W-1:0]    out_slot0_offset,
  output logic [bbtb_pkg::INFO_W-1:0]   out_slot0_info,
  output logic                          out_slot1_valid,
  output logic [bbtb_pkg::OFF_W-1:0]    out_slot1_offset,
  output logic [bbtb_pkg::INFO_W-1:0]   out_slot1_info,
  output logic [bbtb_pkg::PC_W-1:0]     out_fall_through,
  output logic [bbtb_pkg::KIND_W-1:0]   out_kind_flags
);
  import bbtb_pkg::*;
  `include "block_branch_target_buffer_top_assert.svh"

  localparam int IDX_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int KEY_W = TAG_BITS + 1;
  localparam logic [LRU_BITS-1:0] AGE_MAX = {LRU_BITS{1'b1}};
  localparam logic [PC_W-1:0] BLK_BYTES = PC_W'(BLOCK_INSTRS * 2);

  // Set memory, one row per set, split by field but read and written together.
  logic [WAYS-1:0]                val_mem  [SETS];
  logic [WAYS-1:0][LRU_BITS-1:0]  age_mem  [SETS];
  logic [WAYS-1:0][KEY_W-1:0]     key_mem  [SETS];
  slot_t [WAYS-1:0]               s0_mem   [SETS];
  slot_t [WAYS-1:0]               s1_mem   [SETS];
  logic [WAYS-1:0][PC_W-1:0]      ft_mem   [SETS];
  logic [WAYS-1:0][KIND_W-1:0]    kind_mem [SETS];

  logic [WAYS-1:0]                rd_val;
  logic [WAYS-1:0][LRU_BITS-1:0]  rd_age;
  logic [WAYS-1:0][KEY_W-1:0]     rd_key;
  slot_t [WAYS-1:0]               rd_s0;
  slot_t [WAYS-1:0]               rd_s1;
  logic [WAYS-1:0][PC_W-1:0]      rd_ft;
  logic [WAYS-1:0][KIND_W-1:0]    rd_kind;

  logic [WAYS-1:0]                wr_val;
  logic [WAYS-1:0][LRU_BITS-1:0]  wr_age;
  logic [WAYS-1:0][KEY_W-1:0]     wr_key;
  slot_t [WAYS-1:0]               wr_s0;
  slot_t [WAYS-1:0]               wr_s1;
  logic [WAYS-1:0][PC_W-1:0]      wr_ft;
  logic [WAYS-1:0][KIND_W-1:0]    wr_kind;
  logic                           wr_en;
  logic [IDX_W-1:0]               wr_addr;

  state_t state, state_next;
  logic [IDX_W-1:0] clr_cnt;
  logic accept, exec_en, clr_en;

  // Latched command beat.
  op_t              op_q;
  logic [PC_W-1:0]  pc_q;
  logic [KEY_W-1:0] key_q;
  logic [IDX_W-1:0] idx_q;
  logic             hint_q;
  slot_t            n0_q, n1_q;
  logic [PC_W-1:0]  ft_q;
  logic [KIND_W-1:0] kind_q;

  logic [IDX_W-1:0]    idx_in;
  logic [TAG_BITS-1:0] tag_in;

  // Set index and tag of the incoming beat.
  assign idx_in = IDX_W'(pc >> INST_SHIFT) ^ (IDX_W'(tid) << (IDX_W - 1));
  assign tag_in = TAG_BITS'(pc >> (INST_SHIFT + IDX_W));

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == IDX_W'(SETS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_EXEC;
      ST_EXEC:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Control outputs of the state machine.
  always_comb begin
    busy    = (state != ST_IDLE);
    accept  = (state == ST_IDLE) && start;
    exec_en = (state == ST_EXEC);
    clr_en  = (state == ST_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clr_en) clr_cnt <= clr_cnt + IDX_W'(1);
    end
  end

  // Capture the beat and read its set row.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op_t'(operation);
      pc_q    <= pc;
      key_q   <= {tag_in, tid};
      idx_q   <= idx_in;
      hint_q  <= merge_hint;
      n0_q    <= '{info: slot0_info, offset: slot0_offset, valid: slot0_valid};
      n1_q    <= '{info: slot1_info, offset: slot1_offset, valid: slot1_valid};
      ft_q    <= fall_through;
      kind_q  <= kind_flags;
      rd_val  <= val_mem[idx_in];
      rd_age  <= age_mem[idx_in];
      rd_key  <= key_mem[idx_in];
      rd_s0   <= s0_mem[idx_in];
      rd_s1   <= s1_mem[idx_in];
      rd_ft   <= ft_mem[idx_in];
      rd_kind <= kind_mem[idx_in];
    end
  end

  // Way selection and row modification.
  logic [WAY_W-1:0] hw, iw, vw, sw;
  logic             any_hit, any_inv, all_nz;
  logic [LRU_BITS-1:0] best;
  logic [PC_W-1:0]  blk;
  merge_t           mg;

  always_comb begin
    hw = '0; any_hit = 1'b0;
    iw = '0; any_inv = 1'b0;
    vw = '0; best = AGE_MAX;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_val[w] && rd_key[w] == key_q) begin
        hw = WAY_W'(w);
        any_hit = 1'b1;
      end
      if (!rd_val[w]) begin
        iw = WAY_W'(w);
        any_inv = 1'b1;
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (rd_age[w] < best) begin
        best = rd_age[w];
        vw = WAY_W'(w);
      end
    end
  end

  assign sw  = any_hit ? hw : (any_inv ? iw : vw);
  assign blk = pc_q + BLK_BYTES;
  assign mg  = merge_slots(rd_s0[sw], rd_s1[sw], n0_q, pc_q, rd_ft[sw], rd_kind[sw], blk);

  always_comb begin
    wr_val  = rd_val;
    wr_age  = rd_age;
    wr_key  = rd_key;
    wr_s0   = rd_s0;
    wr_s1   = rd_s1;
    wr_ft   = rd_ft;
    wr_kind = rd_kind;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    all_nz  = 1'b1;
    if (clr_en) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_val  = '0;
      wr_age  = '0;
    end else if (exec_en) begin
      case (op_q) inside
        OP_LOOKUP: begin
          if (any_hit) begin
            wr_en = 1'b1;
            if (wr_age[hw] != AGE_MAX) wr_age[hw] = wr_age[hw] + LRU_BITS'(1);
            for (int w = 0; w < WAYS; w++) if (wr_age[w] == '0) all_nz = 1'b0;
            if (all_nz)
              for (int w = 0; w < WAYS; w++) wr_age[w] = wr_age[w] - LRU_BITS'(1);
          end
        end
        OP_ALLOC, OP_UPDATE: begin
          if (any_hit || op_q == OP_ALLOC) begin
            wr_en = 1'b1;
            if (any_hit && ((op_q == OP_ALLOC && !hint_q) ||
                            (op_q == OP_UPDATE && hint_q && rd_s0[sw].valid))) begin
              wr_s0[sw]   = mg.s0;
              wr_s1[sw]   = mg.s1;
              wr_ft[sw]   = mg.ft;
              wr_kind[sw] = mg.kind;
            end else begin
              wr_val[sw]  = 1'b1;
              wr_key[sw]  = key_q;
              wr_s0[sw]   = n0_q;
              wr_s1[sw]   = n1_q;
              wr_ft[sw]   = ft_q;
              wr_kind[sw] = kind_q;
            end
            if (!any_hit) wr_age[sw] = AGE_MAX;
          end
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  // Row write-back.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      val_mem[wr_addr]  <= wr_val;
      age_mem[wr_addr]  <= wr_age;
      key_mem[wr_addr]  <= wr_key;
      s0_mem[wr_addr]   <= wr_s0;
      s1_mem[wr_addr]   <= wr_s1;
      ft_mem[wr_addr]   <= wr_ft;
      kind_mem[wr_addr] <= wr_kind;
    end
  end

  // Result register; the slot, fall-through and kind fields are zero except on a lookup hit.
  logic show;
  assign show = exec_en && op_q == OP_LOOKUP && any_hit;

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= exec_en;
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      hit              <= any_hit && op_q != OP_NONE;
      out_slot0_valid  <= show ? rd_s0[hw].valid  : 1'b0;
      out_slot0_offset <= show ? rd_s0[hw].offset : '0;
      out_slot0_info   <= show ? rd_s0[hw].info   : '0;
      out_slot1_valid  <= show ? rd_s1[hw].valid  : 1'b0;
      out_slot1_offset <= show ? rd_s1[hw].offset : '0;
      out_slot1_info   <= show ? rd_s1[hw].info   : '0;
      out_fall_through <= show ? rd_ft[hw]        : '0;
      out_kind_flags   <= show ? rd_kind[hw]      : '0;
    end
  end

  `BBTB_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy && exec_en, "beat not taken to execute")
  `BBTB_ASSERT_NEXT(a_exec_done, clk, rst, exec_en, done && !busy, "execute gave no result")
  `BBTB_ASSERT_NOW(a_done_idle, clk, rst, done, !exec_en && !clr_en, "result during busy phase")

endmodule
